// ----- sv/bprq_pkg.sv -----
`timescale 1ns / 1ps

package bprq_pkg;

   // Sizes of the scheduler. Both counts are powers of two, so an index wraps by truncation.
   localparam int THREADS         = 32;
   localparam int PRIORITY_LEVELS = 128;
   localparam int TID_W           = $clog2(THREADS);
   localparam int LV_W            = $clog2(PRIORITY_LEVELS);

   // The bitmap is searched one chunk per cycle.
   localparam int CHUNK   = 16;
   localparam int CHUNK_W = $clog2(CHUNK);
   localparam int NCHUNK  = PRIORITY_LEVELS / CHUNK;
   localparam int NCH_W   = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;

   // Field widths of the channels.
   localparam int KIND_FW   = 2;
   localparam int TID_FW    = 5;
   localparam int PRIO_FW   = 7;
   localparam int STATUS_FW = 2;

   typedef logic [TID_W-1:0] tid_type;
   typedef logic [LV_W-1:0]  lv_type;

   typedef enum logic [KIND_FW-1:0] {
      KIND_READY  = 2'd0,
      KIND_REMOVE = 2'd1,
      KIND_SET    = 2'd2,
      KIND_ELECT  = 2'd3
   } kind_type;

   typedef enum logic [STATUS_FW-1:0] {
      ST_OK         = 2'd0,
      ST_QUEUED     = 2'd1,
      ST_NOT_QUEUED = 2'd2,
      ST_NONE_READY = 2'd3
   } status_type;

endpackage

// ----- sv/bprq_if.sv -----
`timescale 1ns / 1ps

// Command channel into the scheduler.
interface bprq_req_if import bprq_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [KIND_FW-1:0]   kind;
   logic [TID_FW-1:0]    target_thread;
   logic [PRIO_FW-1:0]   priority_req;
   logic                 current_running;

   modport source (output valid, kind, target_thread, priority_req, current_running,
                   input ready);
   modport sink   (input valid, kind, target_thread, priority_req, current_running,
                   output ready);
endinterface

// Result channel out of the scheduler.
interface bprq_rsp_if import bprq_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [TID_FW-1:0]    chosen_thread;
   logic [PRIO_FW-1:0]   next_priority;
   logic                 switched;
   logic [STATUS_FW-1:0] status;

   modport source (output valid, chosen_thread, next_priority, switched, status,
                   input ready);
   modport sink   (input valid, chosen_thread, next_priority, switched, status,
                   output ready);
endinterface

// ----- sv/bitmap_priority_ready_queue_scheduler.sv -----
`timescale 1ns / 1ps

// Priority scheduler with one FIFO ready list per level and a bitmap of busy levels.
// Commands arrive on req_port (valid/ready): make ready, remove, set current, elect.
// Every command yields exactly one item on rsp_port with the current thread, its
// level, a switched flag and a status code.
// A small sequencer walks each command through the list memories one step per
// cycle, waiting in its last step while the output register is full; the block
// takes one command at a time. Make ready passes decode, the tail read and the
// append write; remove passes decode and the unlink read and write; set current
// and any command rejected at decode pass only decode. Elect scans the level
// bitmap 16 levels per cycle, then may append the old thread and unlink the new head.
// Ready returns when the result is registered, so the block takes no new
// command before it is through with the last one.
// The head, tail and link memories have one registered read port each, so every
// read takes a step of its own.
// Reset empties the bitmap and the queued flags, sets thread 0 at the least
// urgent level as current and drops any pending result; the list memories need
// no clearing. When the receiver stalls, the next item is still accepted and
// runs until its own result needs the output register, then waits.
module bitmap_priority_ready_queue_scheduler import bprq_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   bprq_req_if.sink   req_port,
   bprq_rsp_if.source rsp_port
);

   typedef enum logic [10:0] {
      S_IDLE     = 11'b000_0000_0001,
      S_DECODE   = 11'b000_0000_0010,
      S_APP_RD   = 11'b000_0000_0100,
      S_APP_WR   = 11'b000_0000_1000,
      S_SCAN     = 11'b000_0001_0000,
      S_ELECT    = 11'b000_0010_0000,
      S_HEAD_RD  = 11'b000_0100_0000,
      S_HEAD_GET = 11'b000_1000_0000,
      S_UNL_RD   = 11'b001_0000_0000,
      S_UNL_WR   = 11'b010_0000_0000,
      S_DONE     = 11'b100_0000_0000
   } state_type;

   state_type state_ff, state_in;

   // Latched command.
   kind_type kind_ff, kind_in;
   tid_type  tid_ff, tid_in;
   lv_type   lv_ff, lv_in;
   logic     run_ff, run_in;

   // Sequencer working registers.
   logic [NCH_W-1:0] chunk_ff, chunk_in;
   lv_type           best_ff, best_in;
   tid_type          app_t_ff, app_t_in;
   lv_type           app_lv_ff, app_lv_in;
   logic             app_ret_ff, app_ret_in;
   tid_type          unl_t_ff, unl_t_in;
   logic             sw_ff, sw_in;
   status_type       status_ff, status_in;

   // Scheduler state held in flip-flops.
   tid_type                    cur_thread_ff, cur_thread_in;
   lv_type                     cur_level_ff, cur_level_in;
   logic [PRIORITY_LEVELS-1:0] bitmap_ff, bitmap_in;
   logic [THREADS-1:0]         queued_ff, queued_in;
   lv_type                     qlevel_ff [THREADS];
   logic                       qlevel_we;
   tid_type                    qlevel_waddr;
   lv_type                     qlevel_wdata;

   // Output register.
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [TID_FW-1:0]    rsp_thread_ff, rsp_thread_in;
   logic [PRIO_FW-1:0]   rsp_prio_ff, rsp_prio_in;
   logic                 rsp_sw_ff, rsp_sw_in;
   logic [STATUS_FW-1:0] rsp_status_ff, rsp_status_in;

   // List memories, one write and one registered read port each.
   tid_type head_mem [PRIORITY_LEVELS];
   tid_type tail_mem [PRIORITY_LEVELS];
   tid_type next_mem [THREADS];
   tid_type prev_mem [THREADS];
   tid_type head_rd_ff, tail_rd_ff, next_rd_ff, prev_rd_ff;
   lv_type  head_raddr, tail_raddr, head_waddr, tail_waddr;
   tid_type next_raddr, prev_raddr, next_waddr, prev_waddr;
   tid_type head_wdata, tail_wdata, next_wdata, prev_wdata;
   logic    head_we, tail_we, next_we, prev_we;

   // Scan of one bitmap chunk.
   logic [CHUNK-1:0]   chunk_bits;
   logic [CHUNK_W-1:0] chunk_low;
   logic               chunk_hit;
   lv_type             unl_lv;
   logic               at_head, at_tail;
   logic               out_free;

   assign chunk_bits = bitmap_ff[{chunk_ff, CHUNK_W'(0)} +: CHUNK];
   assign chunk_hit  = |chunk_bits;

   // Lowest set bit of the chunk.
   always_comb begin
      chunk_low = '0;
      for (int i = CHUNK - 1; i >= 0; i--) begin
         if (chunk_bits[i]) begin
            chunk_low = CHUNK_W'(i);
         end
      end
   end

   assign unl_lv   = qlevel_ff[unl_t_ff];
   assign at_head  = (head_rd_ff == unl_t_ff);
   assign at_tail  = (tail_rd_ff == unl_t_ff);
   assign out_free = !rsp_valid_ff || rsp_port.ready;

   assign req_port.ready = (state_ff == S_IDLE);

   // Sequencer.
   always_comb begin
      state_in      = state_ff;
      kind_in       = kind_ff;
      tid_in        = tid_ff;
      lv_in         = lv_ff;
      run_in        = run_ff;
      chunk_in      = chunk_ff;
      best_in       = best_ff;
      app_t_in      = app_t_ff;
      app_lv_in     = app_lv_ff;
      app_ret_in    = app_ret_ff;
      unl_t_in      = unl_t_ff;
      sw_in         = sw_ff;
      status_in     = status_ff;
      cur_thread_in = cur_thread_ff;
      cur_level_in  = cur_level_ff;
      bitmap_in     = bitmap_ff;
      queued_in     = queued_ff;
      qlevel_we     = 1'b0;
      qlevel_waddr  = app_t_ff;
      qlevel_wdata  = app_lv_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_port.ready;
      rsp_thread_in = rsp_thread_ff;
      rsp_prio_in   = rsp_prio_ff;
      rsp_sw_in     = rsp_sw_ff;
      rsp_status_in = rsp_status_ff;
      head_raddr    = best_ff;
      tail_raddr    = app_lv_ff;
      next_raddr    = unl_t_ff;
      prev_raddr    = unl_t_ff;
      head_we       = 1'b0;
      tail_we       = 1'b0;
      next_we       = 1'b0;
      prev_we       = 1'b0;
      head_waddr    = app_lv_ff;
      tail_waddr    = app_lv_ff;
      next_waddr    = tail_rd_ff;
      prev_waddr    = app_t_ff;
      head_wdata    = app_t_ff;
      tail_wdata    = app_t_ff;
      next_wdata    = app_t_ff;
      prev_wdata    = tail_rd_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_port.valid) begin
               kind_in  = kind_type'(req_port.kind);
               tid_in   = req_port.target_thread[TID_W-1:0];
               lv_in    = req_port.priority_req[LV_W-1:0];
               run_in   = req_port.current_running;
               state_in = S_DECODE;
            end
         end

         S_DECODE: begin
            sw_in      = 1'b0;
            status_in  = ST_OK;
            chunk_in   = '0;
            app_t_in   = tid_ff;
            app_lv_in  = lv_ff;
            app_ret_in = 1'b0;
            unl_t_in   = tid_ff;
            case (kind_ff)
               KIND_READY: begin
                  if (queued_ff[tid_ff]) begin
                     status_in = ST_QUEUED;
                     state_in  = S_DONE;
                  end else begin
                     state_in = S_APP_RD;
                  end
               end
               KIND_REMOVE: begin
                  if (!queued_ff[tid_ff]) begin
                     status_in = ST_NOT_QUEUED;
                     state_in  = S_DONE;
                  end else begin
                     state_in = S_UNL_RD;
                  end
               end
               KIND_SET: begin
                  if (queued_ff[tid_ff]) begin
                     status_in = ST_QUEUED;
                  end else begin
                     cur_thread_in = tid_ff;
                     cur_level_in  = lv_ff;
                  end
                  state_in = S_DONE;
               end
               KIND_ELECT: begin
                  state_in = S_SCAN;
               end
               default: begin
                  state_in = S_DONE;
               end
            endcase
         end

         // Tail of the target level is read here.
         S_APP_RD: begin
            tail_raddr = app_lv_ff;
            state_in   = S_APP_WR;
         end

         S_APP_WR: begin
            if (bitmap_ff[app_lv_ff]) begin
               prev_we = 1'b1;
               next_we = 1'b1;
               tail_we = 1'b1;
            end else begin
               head_we              = 1'b1;
               tail_we              = 1'b1;
               bitmap_in[app_lv_ff] = 1'b1;
            end
            queued_in[app_t_ff] = 1'b1;
            qlevel_we           = 1'b1;
            state_in            = app_ret_ff ? S_HEAD_RD : S_DONE;
         end

         // Most urgent busy level, one chunk per cycle.
         S_SCAN: begin
            if (chunk_hit) begin
               best_in  = {chunk_ff, chunk_low};
               state_in = S_ELECT;
            end else if (chunk_ff == NCH_W'(NCHUNK - 1)) begin
               status_in = ST_NONE_READY;
               state_in  = S_DONE;
            end else begin
               chunk_in = chunk_ff + 1'b1;
            end
         end

         S_ELECT: begin
            if (run_ff && (best_ff >= cur_level_ff)) begin
               state_in = S_DONE;
            end else if (run_ff && !queued_ff[cur_thread_ff]) begin
               // The running thread goes back to the tail of its own level first.
               app_t_in   = cur_thread_ff;
               app_lv_in  = cur_level_ff;
               app_ret_in = 1'b1;
               state_in   = S_APP_RD;
            end else begin
               state_in = S_HEAD_RD;
            end
         end

         S_HEAD_RD: begin
            head_raddr = best_ff;
            state_in   = S_HEAD_GET;
         end

         S_HEAD_GET: begin
            unl_t_in      = head_rd_ff;
            sw_in         = (head_rd_ff != cur_thread_ff);
            cur_thread_in = head_rd_ff;
            cur_level_in  = best_ff;
            state_in      = S_UNL_RD;
         end

         // Neighbors and level ends of the thread to unlink are read here.
         S_UNL_RD: begin
            head_raddr = unl_lv;
            tail_raddr = unl_lv;
            next_raddr = unl_t_ff;
            prev_raddr = unl_t_ff;
            state_in   = S_UNL_WR;
         end

         S_UNL_WR: begin
            head_waddr = unl_lv;
            tail_waddr = unl_lv;
            head_wdata = next_rd_ff;
            tail_wdata = prev_rd_ff;
            next_waddr = prev_rd_ff;
            next_wdata = next_rd_ff;
            prev_waddr = next_rd_ff;
            prev_wdata = prev_rd_ff;
            if (at_head && at_tail) begin
               bitmap_in[unl_lv] = 1'b0;
            end else if (at_head) begin
               head_we = 1'b1;
            end else if (at_tail) begin
               tail_we = 1'b1;
            end else begin
               next_we = 1'b1;
               prev_we = 1'b1;
            end
            queued_in[unl_t_ff] = 1'b0;
            state_in            = S_DONE;
         end

         S_DONE: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_thread_in = TID_FW'(cur_thread_ff);
               rsp_prio_in   = PRIO_FW'(cur_level_ff);
               rsp_sw_in     = sw_ff;
               rsp_status_in = status_ff;
               state_in      = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         cur_thread_ff <= '0;
         cur_level_ff  <= lv_type'(PRIORITY_LEVELS - 1);
         bitmap_ff     <= '0;
         queued_ff     <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cur_thread_ff <= cur_thread_in;
         cur_level_ff  <= cur_level_in;
         bitmap_ff     <= bitmap_in;
         queued_ff     <= queued_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      kind_ff       <= kind_in;
      tid_ff        <= tid_in;
      lv_ff         <= lv_in;
      run_ff        <= run_in;
      chunk_ff      <= chunk_in;
      best_ff       <= best_in;
      app_t_ff      <= app_t_in;
      app_lv_ff     <= app_lv_in;
      app_ret_ff    <= app_ret_in;
      unl_t_ff      <= unl_t_in;
      sw_ff         <= sw_in;
      status_ff     <= status_in;
      rsp_thread_ff <= rsp_thread_in;
      rsp_prio_ff   <= rsp_prio_in;
      rsp_sw_ff     <= rsp_sw_in;
      rsp_status_ff <= rsp_status_in;
      if (qlevel_we) begin
         qlevel_ff[qlevel_waddr] <= qlevel_wdata;
      end
   end

   // List memories.
   always_ff @(posedge clock) begin
      if (head_we) begin
         head_mem[head_waddr] <= head_wdata;
      end
      if (tail_we) begin
         tail_mem[tail_waddr] <= tail_wdata;
      end
      if (next_we) begin
         next_mem[next_waddr] <= next_wdata;
      end
      if (prev_we) begin
         prev_mem[prev_waddr] <= prev_wdata;
      end
      head_rd_ff <= head_mem[head_raddr];
      tail_rd_ff <= tail_mem[tail_raddr];
      next_rd_ff <= next_mem[next_raddr];
      prev_rd_ff <= prev_mem[prev_raddr];
   end

   assign rsp_port.valid         = rsp_valid_ff;
   assign rsp_port.chosen_thread = rsp_thread_ff;
   assign rsp_port.next_priority = rsp_prio_ff;
   assign rsp_port.switched      = rsp_sw_ff;
   assign rsp_port.status        = rsp_status_ff;

   // An accepted command keeps the block busy on the next cycle.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_port.valid && req_port.ready) |=> !req_port.ready)
      else $error("command accepted while the sequencer was busy");

   // Only a successful elect reports a switch.
   a_switch_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_port.valid && rsp_port.switched) |-> (rsp_port.status == ST_OK))
      else $error("switch reported with an error status");

   // A scan that finds no busy level ends the command with no ready thread.
   a_scan_end: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN && !chunk_hit && chunk_ff == NCH_W'(NCHUNK - 1))
      |=> (state_ff == S_DONE && status_ff == ST_NONE_READY))
      else $error("empty scan did not finish with no ready thread");

   // A list is unlinked only for a thread that is queued.
   a_unlink_queued: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_UNL_RD) |-> queued_ff[unl_t_ff])
      else $error("unlink of a thread that is not queued");

endmodule
